>>> sv/set_dedup_union_intersect_diff_top_macros.svh
// ----------------------------------------------------------------------------
// set engine assertion macros
// shared concurrent assertion forms, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SET_DEDUP_UNION_INTERSECT_DIFF_TOP_MACROS_SVH
`define SET_DEDUP_UNION_INTERSECT_DIFF_TOP_MACROS_SVH

// same-cycle implication
`define SDU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sdu_pkg.sv
// ----------------------------------------------------------------------------
// set engine package
// widths, item kind and operation codes, store control bundle
// ----------------------------------------------------------------------------
package sdu_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ELEM_W       = 32;
    localparam int KIND_W       = 2;
    localparam int OP_W         = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN      = 2'd2;

    // operation register codes
    localparam logic [OP_W-1:0] OP_DEDUP     = 2'd0;
    localparam logic [OP_W-1:0] OP_UNION     = 2'd1;
    localparam logic [OP_W-1:0] OP_INTERSECT = 2'd2;
    localparam logic [OP_W-1:0] OP_DIFF      = 2'd3;

    typedef struct packed {
        logic append;
        logic clear;
    } store_ctl_t;

endpackage

>>> sv/sdu_req_if.sv
// ----------------------------------------------------------------------------
// set engine request channel
// input items: kind and element value
// ----------------------------------------------------------------------------
interface sdu_req_if;

    logic                              valid;
    logic                              ready;
    logic [sdu_pkg::KIND_W-1:0]        kind;
    logic signed [sdu_pkg::ELEM_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

>>> sv/sdu_rsp_if.sv
// ----------------------------------------------------------------------------
// set engine result channel
// result elements with last, empty and overflow marks
// ----------------------------------------------------------------------------
interface sdu_rsp_if;

    logic                              valid;
    logic                              ready;
    logic signed [sdu_pkg::ELEM_W-1:0] element;
    logic                              last;
    logic                              empty_res;
    logic                              overflow;

    modport source (output valid, output element, output last, output empty_res,
                    output overflow, input ready);
    modport sink   (input valid, input element, input last, input empty_res,
                    input overflow, output ready);

endinterface

>>> sv/sdu_cfg_if.sv
// ----------------------------------------------------------------------------
// set engine configuration channel
// write port of the operation register
// ----------------------------------------------------------------------------
interface sdu_cfg_if;

    logic                        valid;
    logic                        ready;
    logic [sdu_pkg::OP_W-1:0]    operation;

    modport source (output valid, output operation, input ready);
    modport sink   (input valid, input operation, output ready);

endinterface

>>> sv/set_dedup_union_intersect_diff_top.sv
// appends (kind 0 or 1) and ignored kinds give no result
// a run walks the list a elements (and for union the list b elements) through one shared 32-bit equality compare
// req.ready is high only between runs; results leave through a one-deep output register
// rst_n is asynchronous active low: counts, overflow flag, operation and sequencer cleared
// ----------------------------------------------------------------------------
// set engine top level
// dedup, union, intersection and difference over two stored operand lists
// ----------------------------------------------------------------------------
`include "set_dedup_union_intersect_diff_top_macros.svh"

module set_dedup_union_intersect_diff_top #(
    parameter int  CAPACITY = sdu_pkg::CAPACITY_DEF,
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic clk,
    input  logic rst_n,
    sdu_req_if.sink   req,
    sdu_rsp_if.source rsp,
    sdu_cfg_if.sink   cfg
);

    // sequencer states
    //   idle     : take appends and run items
    //   cand_rd  : issue read of candidate i, or end the list
    //   cand_cap : latch candidate, start the duplicate scan
    //   scan     : stream store entries past the comparator
    //   emit     : push held result out, hold the new one
    //   flush    : send the final (or empty) result and empty the stores
    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND_RD,
        S_CAND_CAP,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } state_t;

    state_t                     state_reg, state_next;
    logic                       phase_b_reg, phase_b_next;    // candidates from list b
    logic                       mem_scan_reg, mem_scan_next;  // membership scan, else dup scan
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           j_reg, j_next;
    logic [CNT_W-1:0]           limit_reg, limit_next;
    logic [sdu_pkg::ELEM_W-1:0] cand_reg, cand_next;
    logic                       hit_reg, hit_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [sdu_pkg::ELEM_W-1:0] pend_reg, pend_next;
    logic                       pend_vld_reg, pend_vld_next;
    logic                       out_vld_reg, out_vld_next;
    logic [sdu_pkg::ELEM_W-1:0] out_elem_reg, out_elem_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_empty_reg, out_empty_next;
    logic                       out_ovf_reg, out_ovf_next;
    logic [sdu_pkg::OP_W-1:0]   op_reg, op_next;
    logic                       dropped_reg, dropped_next;

    sdu_pkg::store_ctl_t        ctl_a, ctl_b;
    logic [IDX_W-1:0]           rd_addr;
    logic [sdu_pkg::ELEM_W-1:0] rd_a, rd_b;
    logic [CNT_W-1:0]           count_a, count_b;
    logic                       full_a, full_b;

    logic [CNT_W-1:0]           cur_n;
    logic [sdu_pkg::ELEM_W-1:0] scan_data;
    logic                       eq;
    logic                       issue;
    logic                       need_mem;
    logic                       keep_mem;
    logic                       out_free;

    // ------------------------------------------------------------------
    // operand stores; both see the same read index, only one is used
    // ------------------------------------------------------------------
    sdu_store #(
        .CAPACITY (CAPACITY)
    ) u_store_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_a),
        .wr_data (req.value),
        .rd_addr (rd_addr),
        .rd_data (rd_a),
        .count   (count_a),
        .full    (full_a)
    );

    sdu_store #(
        .CAPACITY (CAPACITY)
    ) u_store_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_b),
        .wr_data (req.value),
        .rd_addr (rd_addr),
        .rd_data (rd_b),
        .count   (count_b),
        .full    (full_b)
    );

    // ------------------------------------------------------------------
    // datapath around the shared comparator
    // ------------------------------------------------------------------
    assign rd_addr   = (state_reg == S_CAND_RD) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign cur_n     = phase_b_reg ? count_b : count_a;

    // dup scan reads the candidate's own list, membership scan the other one
    assign scan_data = (phase_b_reg ^ mem_scan_reg) ? rd_b : rd_a;
    assign eq        = cmp_vld_reg && (scan_data == cand_reg);
    assign issue     = (j_reg < limit_reg);

    // list b candidates (union tail) always check against a
    assign need_mem  = phase_b_reg || (op_reg == sdu_pkg::OP_INTERSECT)
                       || (op_reg == sdu_pkg::OP_DIFF);
    assign keep_mem  = (!phase_b_reg && (op_reg == sdu_pkg::OP_INTERSECT)) ? hit_reg
                                                                            : !hit_reg;

    assign out_free  = !out_vld_reg || rsp.ready;

    assign req.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_vld_reg;
    assign rsp.element   = out_elem_reg;
    assign rsp.last      = out_last_reg;
    assign rsp.empty_res = out_empty_reg;
    assign rsp.overflow  = out_ovf_reg;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        phase_b_next   = phase_b_reg;
        mem_scan_next  = mem_scan_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        limit_next     = limit_reg;
        cand_next      = cand_reg;
        hit_next       = hit_reg;
        cmp_vld_next   = cmp_vld_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        out_vld_next   = out_vld_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        op_next        = op_reg;
        dropped_next   = dropped_reg;
        ctl_a          = '0;
        ctl_b          = '0;

        // result register empties on a transfer
        if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (cfg.valid)
        begin
            op_next = cfg.operation;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.kind)
                        sdu_pkg::KIND_APPEND_A:
                        begin
                            ctl_a.append = 1'b1;
                            if (full_a)
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        sdu_pkg::KIND_APPEND_B:
                        begin
                            ctl_b.append = 1'b1;
                            if (full_b)
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        sdu_pkg::KIND_RUN:
                        begin
                            i_next       = '0;
                            phase_b_next = 1'b0;
                            state_next   = S_CAND_RD;
                        end
                        default:
                        begin
                            // unused kind, dropped silently
                        end
                    endcase
                end
            end

            S_CAND_RD:
            begin
                if (i_reg == cur_n)
                begin
                    if (!phase_b_reg && (op_reg == sdu_pkg::OP_UNION))
                    begin
                        // union continues with the b elements
                        phase_b_next = 1'b1;
                        i_next       = '0;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    state_next = S_CAND_CAP;
                end
            end

            S_CAND_CAP:
            begin
                cand_next     = phase_b_reg ? rd_b : rd_a;
                j_next        = '0;
                limit_next    = i_reg;   // earlier entries of the same list
                hit_next      = 1'b0;
                cmp_vld_next  = 1'b0;
                mem_scan_next = 1'b0;
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                // one read issued per cycle, compared in the following cycle
                hit_next = hit_reg || eq;
                if (issue)
                begin
                    j_next       = j_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end

                if (!issue && !cmp_vld_reg)
                begin
                    if (!mem_scan_reg)
                    begin
                        if (hit_reg)
                        begin
                            // repeat of an earlier element
                            i_next     = i_reg + CNT_W'(1);
                            state_next = S_CAND_RD;
                        end
                        else if (need_mem)
                        begin
                            mem_scan_next = 1'b1;
                            j_next        = '0;
                            limit_next    = phase_b_reg ? count_a : count_b;
                            hit_next      = 1'b0;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else if (keep_mem)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_CAND_RD;
                    end
                end
            end

            S_EMIT:
            begin
                // one result is held back so the final one can carry last
                if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next   = 1'b1;
                        out_elem_next  = pend_reg;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                        out_ovf_next   = dropped_reg;
                    end
                    pend_next     = cand_reg;
                    pend_vld_next = 1'b1;
                    i_next        = i_reg + CNT_W'(1);
                    state_next    = S_CAND_RD;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_elem_next  = pend_vld_reg ? pend_reg : '0;
                    out_last_next  = 1'b1;
                    out_empty_next = !pend_vld_reg;
                    out_ovf_next   = dropped_reg;
                    pend_vld_next  = 1'b0;
                    dropped_next   = 1'b0;
                    ctl_a.clear    = 1'b1;
                    ctl_b.clear    = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_b_reg   <= 1'b0;
            mem_scan_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            limit_reg     <= '0;
            cand_reg      <= '0;
            hit_reg       <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            pend_reg      <= '0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            out_elem_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
            op_reg        <= sdu_pkg::OP_DEDUP;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_b_reg   <= phase_b_next;
            mem_scan_reg  <= mem_scan_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            limit_reg     <= limit_next;
            cand_reg      <= cand_next;
            hit_reg       <= hit_next;
            cmp_vld_reg   <= cmp_vld_next;
            pend_reg      <= pend_next;
            pend_vld_reg  <= pend_vld_next;
            out_vld_reg   <= out_vld_next;
            out_elem_reg  <= out_elem_next;
            out_last_reg  <= out_last_next;
            out_empty_reg <= out_empty_next;
            out_ovf_reg   <= out_ovf_next;
            op_reg        <= op_next;
            dropped_reg   <= dropped_next;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SDU_ASSERT_IMP(a_idle_clean, state_reg == S_IDLE,
                    !pend_vld_reg && !cmp_vld_reg, "held result or compare left over in idle")
    `SDU_ASSERT_IMP(a_empty_is_last, rsp.valid && rsp.empty_res, rsp.last,
                    "empty result without last mark")
    `SDU_ASSERT_NXT(a_flush_clears, state_reg == S_FLUSH && out_free,
                    count_a == '0 && count_b == '0 && !dropped_reg, "stores not emptied after run")
    `SDU_ASSERT_IMP(a_count_bound, 1'b1,
                    count_a <= CNT_W'(CAPACITY) && count_b <= CNT_W'(CAPACITY),
                    "store count above capacity")

endmodule

>>> sv/sdu_store.sv
// ----------------------------------------------------------------------------
// set engine operand store
// append-only element memory with fill count and registered read port
// ----------------------------------------------------------------------------
module sdu_store #(
    parameter int  CAPACITY = sdu_pkg::CAPACITY_DEF,
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sdu_pkg::store_ctl_t        ctl,
    input  logic [sdu_pkg::ELEM_W-1:0] wr_data,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [sdu_pkg::ELEM_W-1:0] rd_data,
    output logic [CNT_W-1:0]           count,
    output logic                       full
);

    logic [sdu_pkg::ELEM_W-1:0] mem [CAPACITY];
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.append && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // no reset on the array, only written entries are ever used
    always_ff @(posedge clk)
    begin
        if (ctl.append && !full)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> tb/sv/tb_set_dedup_union_intersect_diff_top.sv
// ----------------------------------------------------------------------------
// set engine testbench
// drives appends, runs and operation writes into the set engine, mirrors both
// stores and the overflow flag, and checks every result element in order
// against a behavioral predictor of dedup, union, intersection and difference
// ----------------------------------------------------------------------------
module tb_set_dedup_union_intersect_diff_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sdu_pkg::*;

    // ------------------------------------------------------------------
    // run constants
    // ------------------------------------------------------------------
    localparam int SET_DEPTH      = CAPACITY_DEF;
    localparam int IDLE_PCT       = 34;      // chance per cycle that a side idles
    localparam int HOLD_CYCLES    = 400;     // long receiver hold-off
    localparam int SETTLE_CYCLES  = 20;      // settle time after the drain
    localparam int END_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int TOTAL_ITEMS    = 210;     // directed part included
    localparam int PRINT_LIMIT    = 40;

    // kind 3 is not decoded by the block
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        elem_t element;
        logic  last;
        logic  empty_res;
        logic  overflow;
    } set_result_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        elem_t             value;
    } set_item_t;

    // ------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sdu_req_if req ();
    sdu_rsp_if rsp ();
    sdu_cfg_if cfg ();

    // input side registers, known from time zero
    logic              req_valid = 1'b0;
    logic [KIND_W-1:0] req_kind  = '0;
    elem_t             req_value = '0;
    logic              rsp_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [OP_W-1:0]   cfg_op    = '0;

    assign req.valid     = req_valid;
    assign req.kind      = req_kind;
    assign req.value     = req_value;
    assign rsp.ready     = rsp_ready;
    assign cfg.valid     = cfg_valid;
    assign cfg.operation = cfg_op;

    set_dedup_union_intersect_diff_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // shared state
    // ------------------------------------------------------------------
    set_item_t   items_queued[$];     // items waiting for the driver
    set_result_t elements_due[$];     // predicted results, oldest first

    // mirror of the block state
    elem_t           a_store[SET_DEPTH];
    elem_t           b_store[SET_DEPTH];
    int              a_count    = 0;
    int              b_count    = 0;
    logic            dropped    = 1'b0;
    logic [OP_W-1:0] op_mirror  = OP_DEDUP;

    logic req_taken    = 1'b0;        // request transfer at the last rising edge
    logic steady_phase = 1'b0;        // no idling on either side
    int   holds_asked  = 0;
    int   holds_served = 0;
    int   hold_left    = 0;

    // bookkeeping
    int errors          = 0;
    int items_counted   = 0;          // queued items the block acts on
    int items_sent      = 0;
    int results_checked = 0;
    int runs_by_op[4]   = '{0, 0, 0, 0};
    int overflow_runs   = 0;
    int empty_runs      = 0;
    int idle_cycles     = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // keep first occurrences, in order
    function automatic void first_occurrences(input elem_t src[SET_DEPTH], input int n,
                                              output elem_t dst[$]);
        bit seen;
        dst.delete();
        for (int i = 0; i < n; i++)
        begin
            seen = 1'b0;
            foreach (dst[j])
                if (dst[j] == src[i])
                    seen = 1'b1;
            if (!seen)
                dst.push_back(src[i]);
        end
    endfunction

    function automatic bit is_member(input elem_t list[$], input elem_t x);
        foreach (list[i])
            if (list[i] == x)
                return 1'b1;
        return 1'b0;
    endfunction

    // update the mirrored stores for one accepted item; a run queues its results
    function automatic void apply_set_item(input logic [KIND_W-1:0] kind, input elem_t value);
        elem_t       uniq_a[$];
        elem_t       uniq_b[$];
        elem_t       found[$];
        set_result_t r;
        if (kind == KIND_APPEND_A)
        begin
            if (a_count < SET_DEPTH)
            begin
                a_store[a_count] = value;
                a_count++;
            end
            else
                dropped = 1'b1;
        end
        else if (kind == KIND_APPEND_B)
        begin
            if (b_count < SET_DEPTH)
            begin
                b_store[b_count] = value;
                b_count++;
            end
            else
                dropped = 1'b1;
        end
        else if (kind == KIND_RUN)
        begin
            first_occurrences(a_store, a_count, uniq_a);
            first_occurrences(b_store, b_count, uniq_b);
            case (op_mirror)
                OP_DEDUP:
                    found = uniq_a;
                OP_UNION:
                begin
                    found = uniq_a;
                    foreach (uniq_b[i])
                        if (!is_member(uniq_a, uniq_b[i]))
                            found.push_back(uniq_b[i]);
                end
                OP_INTERSECT:
                    foreach (uniq_a[i])
                        if (is_member(uniq_b, uniq_a[i]))
                            found.push_back(uniq_a[i]);
                default:
                    foreach (uniq_a[i])
                        if (!is_member(uniq_b, uniq_a[i]))
                            found.push_back(uniq_a[i]);
            endcase
            // empty result set still gives one transfer, flagged empty
            if (found.size() == 0)
            begin
                r = '{element: '0, last: 1'b1, empty_res: 1'b1, overflow: dropped};
                elements_due.push_back(r);
                empty_runs++;
            end
            else
                foreach (found[i])
                begin
                    r = '{element: found[i], last: (i == found.size() - 1),
                          empty_res: 1'b0, overflow: dropped};
                    elements_due.push_back(r);
                end
            runs_by_op[op_mirror]++;
            if (dropped)
                overflow_runs++;
            a_count = 0;
            b_count = 0;
            dropped = 1'b0;
        end
        // kind 3 leaves everything as it is
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input elem_t want, input elem_t got);
        if (errors < PRINT_LIMIT)
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     field, results_checked, want, got);
        errors++;
    endtask

    task automatic check_element();
        set_result_t want;
        if (elements_due.size() == 0)
        begin
            report_mismatch("unexpected result", '0, rsp.element);
            return;
        end
        want = elements_due.pop_front();
        if (rsp.element !== want.element)
            report_mismatch("element", want.element, rsp.element);
        if (rsp.last !== want.last)
            report_mismatch("last", elem_t'(want.last), elem_t'(rsp.last));
        if (rsp.empty_res !== want.empty_res)
            report_mismatch("empty_res", elem_t'(want.empty_res), elem_t'(rsp.empty_res));
        if (rsp.overflow !== want.overflow)
            report_mismatch("overflow", elem_t'(want.overflow), elem_t'(rsp.overflow));
        results_checked++;
    endtask

    // monitor: every transfer is seen at the rising edge, predictor first
    always @(posedge clk)
    begin
        req_taken <= rst_n && req.valid && req.ready;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                apply_set_item(req.kind, req.value);
                items_sent++;
            end
            if (rsp.valid && rsp.ready)
                check_element();
            if (cfg.valid && cfg.ready)
                op_mirror = cfg.operation;

            // watchdog on cycles with no transfer on any channel
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, elements_due.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: request items leave the queue at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : send_items
        set_item_t it;
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            // a held item stays put until its transfer, otherwise pick or idle
            if (items_queued.size() != 0 &&
                (steady_phase || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                it = items_queued.pop_front();
                req_valid <= 1'b1;
                req_kind  <= it.kind;
                req_value <= it.value;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver hold-off counter, started on request from the sequencer
    always @(negedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_served != holds_asked)
        begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    // receiver ready: low during a hold-off, random idling otherwise
    always @(negedge clk)
    begin
        rsp_ready <= rst_n && (hold_left == 0) &&
                     (steady_phase || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [KIND_W-1:0] kind, input elem_t value);
        set_item_t it;
        it.kind  = kind;
        it.value = value;
        items_queued.push_back(it);
        if (kind != KIND_UNUSED)
            items_counted++;
    endtask

    // mostly a narrow pool so that lists share and repeat values
    function automatic elem_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            8, 9:    return elem_t'($urandom);
            default: return elem_t'(int'($urandom_range(0, 9)) - 5);
        endcase
    endfunction

    // one loading sequence for both lists, then a run; now and then a list
    // is overfilled, a stray kind 3 slips in, or the run comes bare
    task automatic queue_sequence();
        int n_a;
        int n_b;
        int ia;
        int ib;
        n_a = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
        n_b = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0)
        begin
            n_a = 0;
            n_b = 0;
        end
        ia = 0;
        ib = 0;
        while (ia < n_a || ib < n_b)
        begin
            if (ib >= n_b || (ia < n_a && $urandom_range(0, 1) == 1))
            begin
                queue_item(KIND_APPEND_A, pick_value());
                ia++;
            end
            else
            begin
                queue_item(KIND_APPEND_B, pick_value());
                ib++;
            end
            if ($urandom_range(0, 19) == 0)
                queue_item(KIND_UNUSED, elem_t'($urandom));
        end
        queue_item(KIND_RUN, elem_t'($urandom));
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_queued.size() != 0 || req_valid || elements_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // operation register write, entered at a falling edge
    task automatic write_operation(input logic [OP_W-1:0] op);
        cfg_valid <= 1'b1;
        cfg_op    <= op;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // block idle, new operation, then queue from the next rising edge
    task automatic start_phase(input logic [OP_W-1:0] op);
        wait_drained();
        write_operation(op);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int phase;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes, a repeated minimum, an unused kind, and a run on empty stores
        start_phase(OP_DEDUP);
        queue_item(KIND_APPEND_A, 32'sh7FFF_FFFF);
        queue_item(KIND_APPEND_A, 32'sh8000_0000);
        queue_item(KIND_APPEND_A, 32'sd0);
        queue_item(KIND_APPEND_A, -32'sd1);
        queue_item(KIND_APPEND_A, 32'sh8000_0000);
        queue_item(KIND_APPEND_B, 32'sd5);
        queue_item(KIND_UNUSED, -32'sd1);
        queue_item(KIND_RUN, 32'sh5555_5555);
        queue_item(KIND_RUN, 32'shAAAA_AAAA);

        // union with overlap and reordering in B
        start_phase(OP_UNION);
        queue_item(KIND_APPEND_A, 32'sd1);
        queue_item(KIND_APPEND_A, 32'sd2);
        queue_item(KIND_APPEND_B, 32'sd2);
        queue_item(KIND_APPEND_B, 32'sd3);
        queue_item(KIND_APPEND_B, 32'sd1);
        queue_item(KIND_APPEND_B, 32'sd4);
        queue_item(KIND_RUN, 32'sd0);

        // intersection with nothing shared gives the empty flag
        start_phase(OP_INTERSECT);
        queue_item(KIND_APPEND_A, 32'sd3);
        queue_item(KIND_APPEND_A, 32'sd4);
        queue_item(KIND_APPEND_B, 32'sd5);
        queue_item(KIND_RUN, 32'sd0);

        // difference with a duplicate in A
        start_phase(OP_DIFF);
        queue_item(KIND_APPEND_A, 32'sd9);
        queue_item(KIND_APPEND_A, 32'sd9);
        queue_item(KIND_APPEND_A, 32'sd8);
        queue_item(KIND_APPEND_B, 32'sd8);
        queue_item(KIND_RUN, -32'sd1);

        // random phases, each behind a drain and an operation write; the first
        // four walk through every operation, one phase never idles, and two
        // phases open with a long receiver hold while the sender keeps offering
        for (phase = 0; items_counted < TOTAL_ITEMS; phase++)
        begin
            start_phase((phase < 4) ? OP_W'(3 - phase) : OP_W'($urandom_range(0, 3)));
            steady_phase = (phase == 2);
            if (phase == 1 || phase == 6)
                holds_asked++;
            repeat ($urandom_range(2, 4)) queue_sequence();
        end

        wait_drained();
        steady_phase = 1'b0;
        repeat (END_CYCLES) @(posedge clk);

        if (elements_due.size() != 0)
            report_mismatch("results never delivered", elem_t'(elements_due.size()), '0);

        $display("covered %0d transfers in, %0d results checked; runs: dedup %0d, union %0d,",
                 items_sent, results_checked, runs_by_op[OP_DEDUP], runs_by_op[OP_UNION]);
        $display("  intersect %0d, diff %0d; %0d with dropped appends, %0d empty; %0d errors",
                 runs_by_op[OP_INTERSECT], runs_by_op[OP_DIFF], overflow_runs, empty_runs,
                 errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
